// ----- rtl/kci_pkg.sv -----
// Package with the codes, widths and state type of the keyframe curve interpolator.
`timescale 1ns / 1ps
`default_nettype none
package kci_pkg;

  // Item function codes.
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_BY_TIME = 2'd1;
  localparam logic [1:0] FUNC_BY_VALUE = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_INTERP = 3'd0;
  localparam logic [2:0] ST_LOW = 3'd1;
  localparam logic [2:0] ST_HIGH = 3'd2;
  localparam logic [2:0] ST_FLAT = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;
  localparam logic [2:0] ST_WRITTEN = 3'd5;

  // Configuration register indexes.
  localparam logic CFG_KEY_COUNT = 1'b0;
  localparam logic CFG_FLAT_TOL = 1'b1;

  // Fraction bits of the interpolation ratio; one quotient bit per divide step.
  localparam int FRAC_BITS = 30;
  localparam logic [4:0] DIV_STEPS = 5'd30;

  // Sequencer states.
  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_SRCH  = 11'b00000000010,
    S_CMP   = 11'b00000000100,
    S_CLAMP = 11'b00000001000,
    S_RDA   = 11'b00000010000,
    S_RDB   = 11'b00000100000,
    S_CALC  = 11'b00001000000,
    S_DIV   = 11'b00010000000,
    S_MUL   = 11'b00100000000,
    S_ADJ   = 11'b01000000000,
    S_FIN   = 11'b10000000000
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/kci_if.sv -----
// Valid/ready channel interfaces for the input items and the result items.
`timescale 1ns / 1ps
`default_nettype none
interface kci_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [5:0]         key_index;
  logic signed [31:0] key_time;
  logic signed [31:0] key_value;
  logic signed [31:0] query;

  modport source (output valid, func, key_index, key_time, key_value, query, input ready);
  modport sink (input valid, func, key_index, key_time, key_value, query, output ready);
endinterface

interface kci_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample;
  logic [2:0]         status;

  modport source (output valid, sample, status, input ready);
  modport sink (input valid, sample, status, output ready);
endinterface
`default_nettype wire

// ----- rtl/keyframe_curve_interpolator_top.sv -----
// A key write, an empty-table query or an unknown function goes from idle to the finish
// state; a query spends a search and a compare state per probe (log2 of the key count
// plus one probes), then the clamp state, or the segment reads and the calculation, then
// if needed the 30-step divider, the multiply and the adjust step. The finish state waits
// for the output register to free up. Items go one at a time (ready only in idle); a new
// item is taken while the previous result waits in the output register. Reset (synchronous,
// active low) sets key_count to 0 and flat_tolerance to 1; the key memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module keyframe_curve_interpolator_top
  import kci_pkg::*;
#(
  parameter int MAX_KEYS = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  kci_in_if.sink      in_ch,
  kci_out_if.source   out_ch,
  input  wire         cfg_we,
  input  wire         cfg_index,
  input  wire  [16:0] cfg_data
);

  localparam int AW = $clog2(MAX_KEYS);
  localparam int CW = $clog2(MAX_KEYS + 1);

  // Key memory: each entry is {time, value}.
  logic [63:0] mem [MAX_KEYS];
  logic [63:0] rd_data_r;
  logic [AW-1:0] rd_addr;
  logic        mem_we;

  state_t state_r;
  logic [6:0]  key_count_r;
  logic [16:0] flat_tol_r;
  logic        inv_r;
  logic signed [31:0] q_r;
  logic [CW-1:0] n_r, first_r, count_r;
  logic signed [31:0] c_lo_r, o_lo_r, c_hi_r, o_hi_r;
  logic signed [32:0] dout_r;
  logic [31:0] dc_r, rem_r;
  logic [FRAC_BITS-1:0] quo_r;
  logic [4:0]  div_cnt_r;
  logic signed [63:0] prod_r;
  logic signed [31:0] res_r;
  logic [2:0]  st_r;
  logic        out_valid_r;
  logic signed [31:0] out_sample_r;
  logic [2:0]  out_status_r;

  // Selects the searched or the interpolated column of an entry.
  function automatic logic signed [31:0] col_of(input logic [63:0] e, input logic inv);
    return inv ? $signed(e[31:0]) : $signed(e[63:32]);
  endfunction

  logic in_acc;
  logic [CW-1:0] n_in;
  logic [CW-1:0] probe;
  logic signed [32:0] dc_w, dq_w;
  logic [32:0] dc_mag;
  logic signed [32:0] flat_sum;
  logic [32:0] rem2;
  logic signed [63:0] prod_adj;
  logic signed [34:0] adj_sum;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc = in_ch.valid & in_ch.ready;
  assign n_in = (32'(key_count_r) > MAX_KEYS) ? CW'(MAX_KEYS) : CW'(key_count_r);
  assign probe = first_r + (count_r >> 1);

  assign out_ch.valid = out_valid_r;
  assign out_ch.sample = out_sample_r;
  assign out_ch.status = out_status_r;

  // Segment arithmetic for the calculation step.
  assign dc_w = 33'(c_hi_r) - 33'(c_lo_r);
  assign dq_w = 33'(q_r) - 33'(c_lo_r);
  assign dc_mag = dc_w[32] ? 33'(-dc_w) : 33'(dc_w);
  assign flat_sum = 33'(o_lo_r) + 33'(o_hi_r);
  assign rem2 = {rem_r, 1'b0};
  assign prod_adj = prod_r + (prod_r[63] ? 64'((64'd1 << FRAC_BITS) - 1) : 64'd0);
  assign adj_sum = 35'(o_lo_r) + 35'(prod_adj >>> FRAC_BITS);

  // Memory address and write strobe.
  always_comb begin
    rd_addr = '0;
    if (state_r == S_SRCH) begin
      if (count_r != '0) begin
        rd_addr = AW'(probe);
      end else if (first_r == '0) begin
        rd_addr = '0;
      end else if (first_r >= n_r) begin
        rd_addr = AW'(n_r - 1'b1);
      end else begin
        rd_addr = AW'(first_r - 1'b1);
      end
    end else if (state_r == S_RDA) begin
      rd_addr = AW'(first_r);
    end
    mem_we = in_acc && (in_ch.func == FUNC_WRITE) && (32'(in_ch.key_index) < MAX_KEYS);
  end

  // Key memory with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(in_ch.key_index)] <= {in_ch.key_time, in_ch.key_value};
    end
    rd_data_r <= mem[rd_addr];
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r <= 7'd0;
      flat_tol_r <= 17'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_COUNT: key_count_r <= cfg_data[6:0];
        CFG_FLAT_TOL:  flat_tol_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: search, clamp or segment read, divide, multiply, result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // The finish state always leaves the output register full.
      if (out_ch.ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            q_r <= in_ch.query;
            inv_r <= (in_ch.func == FUNC_BY_VALUE);
            n_r <= n_in;
            first_r <= '0;
            count_r <= n_in;
            res_r <= '0;
            priority if (in_ch.func == FUNC_WRITE) begin
              st_r <= ST_WRITTEN;
              state_r <= S_FIN;
            end else if (in_ch.func != FUNC_BY_TIME && in_ch.func != FUNC_BY_VALUE) begin
              st_r <= ST_INTERP;
              state_r <= S_FIN;
            end else if (n_in == '0) begin
              st_r <= ST_EMPTY;
              state_r <= S_FIN;
            end else begin
              state_r <= S_SRCH;
            end
          end
        end
        S_SRCH: begin
          priority if (count_r != '0) begin
            state_r <= S_CMP;
          end else if (first_r == '0) begin
            st_r <= ST_LOW;
            state_r <= S_CLAMP;
          end else if (first_r >= n_r) begin
            st_r <= ST_HIGH;
            state_r <= S_CLAMP;
          end else begin
            state_r <= S_RDA;
          end
        end
        S_CMP: begin
          if (col_of(rd_data_r, inv_r) < q_r) begin
            first_r <= probe + 1'b1;
            count_r <= count_r - (count_r >> 1) - 1'b1;
          end else begin
            count_r <= count_r >> 1;
          end
          state_r <= S_SRCH;
        end
        S_CLAMP: begin
          res_r <= col_of(rd_data_r, !inv_r);
          state_r <= S_FIN;
        end
        S_RDA: begin
          c_lo_r <= col_of(rd_data_r, inv_r);
          o_lo_r <= col_of(rd_data_r, !inv_r);
          state_r <= S_RDB;
        end
        S_RDB: begin
          c_hi_r <= col_of(rd_data_r, inv_r);
          o_hi_r <= col_of(rd_data_r, !inv_r);
          state_r <= S_CALC;
        end
        S_CALC: begin
          dout_r <= 33'(o_hi_r) - 33'(o_lo_r);
          dc_r <= dc_w[31:0];
          st_r <= ST_INTERP;
          priority if (inv_r && dc_mag < 33'(flat_tol_r)) begin
            // Flat segment: mean of the two times, truncated toward zero.
            res_r <= 32'((flat_sum + 33'(flat_sum[32])) >>> 1);
            st_r <= ST_FLAT;
            state_r <= S_FIN;
          end else if (dc_w <= 0) begin
            res_r <= o_lo_r;
            state_r <= S_FIN;
          end else if (dq_w >= dc_w) begin
            // Ratio of one lands exactly on the upper key.
            res_r <= o_hi_r;
            state_r <= S_FIN;
          end else if (dq_w <= 0) begin
            res_r <= o_lo_r;
            state_r <= S_FIN;
          end else begin
            rem_r <= dq_w[31:0];
            quo_r <= '0;
            div_cnt_r <= DIV_STEPS;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          // One restoring divide step per cycle.
          if (rem2 >= 33'(dc_r)) begin
            rem_r <= 32'(rem2 - 33'(dc_r));
            quo_r <= {quo_r[FRAC_BITS-2:0], 1'b1};
          end else begin
            rem_r <= rem2[31:0];
            quo_r <= {quo_r[FRAC_BITS-2:0], 1'b0};
          end
          div_cnt_r <= div_cnt_r - 1'b1;
          if (div_cnt_r == 5'd1) begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r <= 64'($signed({1'b0, quo_r})) * 64'(dout_r);
          state_r <= S_ADJ;
        end
        S_ADJ: begin
          // Saturate to the signed 32-bit range.
          priority if (adj_sum > 35'sd2147483647) begin
            res_r <= 32'sh7FFFFFFF;
          end else if (adj_sum < -35'sd2147483648) begin
            res_r <= 32'sh80000000;
          end else begin
            res_r <= adj_sum[31:0];
          end
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_sample_r <= res_r;
            out_status_r <= st_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state register is not one-hot");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n) in_acc |=> state_r != S_IDLE)
    else $error("accepted item did not start work");
  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> div_cnt_r != 5'd0)
    else $error("divider ran past its last step");
  a_fin: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN && !out_valid_r |=> out_valid_r && state_r == S_IDLE)
    else $error("finished result was not delivered to the output register");
`endif

endmodule
`default_nettype wire

// ----- bench/tb_keyframe_curve_interpolator_top.sv -----
// Self-checking testbench for the keyframe curve interpolator: key writes and sampled queries.
`timescale 1ns / 1ps
`default_nettype none
module tb_keyframe_curve_interpolator_top;
  import kci_pkg::*;

  localparam int NKEYS = 64;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [1:0] FUNC_UNKNOWN = 2'd3;

  // Idling modes of the phases.
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [5:0]         key_index;
    logic signed [31:0] key_time;
    logic signed [31:0] key_value;
    logic signed [31:0] query;
  } key_item_t;

  typedef struct packed {
    logic signed [31:0] sample;
    logic [2:0]         status;
  } sample_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_KEY_COUNT;
  logic [16:0] cfg_data = '0;

  kci_in_if  in_ch();
  kci_out_if out_ch();

  keyframe_curve_interpolator_top #(.MAX_KEYS(NKEYS)) i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Pending transactions, expected results and the predictor's copy of the block state.
  key_item_t          send_q[$];
  sample_result_t     sample_q[$];
  logic signed [31:0] pred_times[NKEYS];
  logic signed [31:0] pred_values[NKEYS];
  logic [6:0]         pred_count = 7'd0;
  logic [16:0]        pred_tol = 17'd1;
  idle_mode_t         mode = IDLE_NONE;
  bit                 hold_req = 1'b0;
  int                 err_count = 0;
  int                 cycles = 0;

  // Shadow of what the stimulus wrote, used to aim queries at the curve.
  logic signed [31:0] gen_times[NKEYS];
  logic signed [31:0] gen_values[NKEYS];

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  function automatic logic signed [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Lower-bound search on one column, then linear interpolation on the other.
  function automatic sample_result_t interpolate(input bit by_value, input longint q);
    sample_result_t res;
    int n, first, count, step, probe, hi, lo;
    longint c_lo, c_hi, o_lo, o_hi, dc, dq, r;
    n = (pred_count > NKEYS) ? NKEYS : pred_count;
    res.sample = '0;
    if (n == 0) begin
      res.status = ST_EMPTY;
      return res;
    end
    first = 0;
    count = n;
    while (count > 0) begin
      step = count / 2;
      probe = first + step;
      if ((by_value ? pred_values[probe] : pred_times[probe]) < q) begin
        first = probe + 1;
        count -= step + 1;
      end else begin
        count = step;
      end
    end
    hi = first;
    if (hi == 0) begin
      res.sample = by_value ? pred_times[0] : pred_values[0];
      res.status = ST_LOW;
      return res;
    end
    if (hi >= n) begin
      res.sample = by_value ? pred_times[n-1] : pred_values[n-1];
      res.status = ST_HIGH;
      return res;
    end
    lo = hi - 1;
    c_lo = by_value ? pred_values[lo] : pred_times[lo];
    c_hi = by_value ? pred_values[hi] : pred_times[hi];
    o_lo = by_value ? pred_times[lo] : pred_values[lo];
    o_hi = by_value ? pred_times[hi] : pred_values[hi];
    dc = c_hi - c_lo;
    // Inverse queries treat a nearly level segment as flat and return the mean time.
    if (by_value && ((dc < 0) ? -dc : dc) < longint'(pred_tol)) begin
      res.sample = clip32((o_lo + o_hi) / 2);
      res.status = ST_FLAT;
      return res;
    end
    if (dc <= 0) begin
      r = 0;
    end else begin
      dq = q - c_lo;
      if (dq < 0) dq = 0;
      if (dq > dc) dq = dc;
      r = (dq <<< 30) / dc;
    end
    res.sample = clip32(o_lo + (r * (o_hi - o_lo)) / (64'sd1 <<< 30));
    res.status = ST_INTERP;
    return res;
  endfunction

  // Driver: offers pending transactions and predicts each one as it is accepted.
  always @(posedge clk) begin
    sample_result_t res;
    key_item_t it;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.func <= FUNC_WRITE;
      in_ch.key_index <= '0;
      in_ch.key_time <= '0;
      in_ch.key_value <= '0;
      in_ch.query <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        res.sample = '0;
        res.status = ST_INTERP;
        case (in_ch.func)
          FUNC_WRITE: begin
            pred_times[in_ch.key_index] = in_ch.key_time;
            pred_values[in_ch.key_index] = in_ch.key_value;
            res.status = ST_WRITTEN;
          end
          FUNC_BY_TIME: res = interpolate(1'b0, in_ch.query);
          FUNC_BY_VALUE: res = interpolate(1'b1, in_ch.query);
          default: ;
        endcase
        sample_q.insert(sample_q.size(), res);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_q.size() > 0 &&
            !((mode == IDLE_SEND && $urandom_range(0, 99) < 85) ||
              (mode == IDLE_BOTH && $urandom_range(0, 99) < 16))) begin
          it = send_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.func <= it.func;
          in_ch.key_index <= it.key_index;
          in_ch.key_time <= it.key_time;
          in_ch.key_value <= it.key_value;
          in_ch.query <= it.query;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver readiness, held low while a long hold-off is requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !hold_req &&
                      !((mode == IDLE_RECV && $urandom_range(0, 99) < 85) ||
                        (mode == IDLE_BOTH && $urandom_range(0, 99) < 16));
    end
  end

  // Hold-off timer in its own process.
  always begin
    wait (hold_req);
    repeat (400) @(posedge clk);
    hold_req = 1'b0;
  end

  // Monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    sample_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (sample_q.size() == 0) begin
        report_mismatch("unexpected result, status", out_ch.status, -1);
      end else begin
        want = sample_q.pop_front();
        if (out_ch.sample !== want.sample) report_mismatch("sample", out_ch.sample, want.sample);
        if (out_ch.status !== want.status) report_mismatch("status", out_ch.status, want.status);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_keyframe_curve_interpolator_top: done, errors");
      $finish;
    end
  end

  task automatic write_cfg(input logic idx, input logic [16:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_KEY_COUNT) pred_count = data[6:0];
    else pred_tol = data;
  endtask

  task automatic push_key(input int idx, input logic signed [31:0] t, input logic signed [31:0] v);
    key_item_t it;
    it.func = FUNC_WRITE;
    it.key_index = idx[5:0];
    it.key_time = t;
    it.key_value = v;
    it.query = $urandom;
    gen_times[idx] = t;
    gen_values[idx] = v;
    send_q.insert(send_q.size(), it);
  endtask

  task automatic push_query(input logic [1:0] func, input logic signed [31:0] q);
    key_item_t it;
    it.func = func;
    it.key_index = 6'($urandom);
    it.key_time = $urandom;
    it.key_value = $urandom;
    it.query = q;
    send_q.insert(send_q.size(), it);
  endtask

  // Waits until every transaction is sent and answered, then lets the block settle.
  task automatic drain();
    do begin
      @(negedge clk);
    end while (send_q.size() != 0 || in_ch.valid || sample_q.size() != 0);
    repeat (80) @(posedge clk);
  endtask

  // Writes a curve over entries 0..m-1: ascending columns, now and then scrambled or level.
  task automatic build_curve(input int m);
    longint t, v;
    int shape;
    shape = $urandom_range(0, 9);
    t = -longint'($urandom_range(0, 32'h40000000));
    v = -longint'($urandom_range(0, 32'h40000000));
    for (int i = 0; i < m; i++) begin
      t += $urandom_range(1, 32'h01000000);
      if (shape == 0) v = $signed(32'($urandom));
      else if (shape == 1) v += $urandom_range(0, 3);
      else v += $urandom_range(0, 32'h01000000);
      push_key(i, clip32(t), clip32(v));
    end
  endtask

  // Query aimed near a random key of the chosen column.
  function automatic logic signed [31:0] near_key(input bit by_value, input int m);
    int j;
    longint base;
    j = $urandom_range(0, m - 1);
    base = by_value ? gen_values[j] : gen_times[j];
    return clip32(base + longint'($urandom_range(0, 32'h02000000)) - 64'sd16777216);
  endfunction

  initial begin
    int counts[8];
    int m, r;
    logic [1:0] f;
    counts = '{64, 2, 17, 1, 100, 33, 5, 64};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty table, unknown function, then a full table with extreme keys.
    push_query(FUNC_BY_TIME, 32'sh12345678);
    push_query(FUNC_BY_VALUE, 32'sh80000000);
    push_query(FUNC_UNKNOWN, 32'sh7fffffff);
    for (int i = 0; i < NKEYS; i++)
      push_key(i, (i == NKEYS - 1) ? 32'sh7fffffff : 32'sh80000000 + i * 32'sh04000000,
               32'sh80000000 + i * 32'sh04000000 + ((i == 5 || i == 6) ? 0 : i));
    drain();
    write_cfg(CFG_KEY_COUNT, 17'd64);
    write_cfg(CFG_FLAT_TOL, 17'd0);
    push_query(FUNC_BY_TIME, 32'sh80000000);
    push_query(FUNC_BY_TIME, 32'sh7fffffff);
    push_query(FUNC_BY_TIME, 32'sh84000000);
    push_query(FUNC_BY_TIME, 32'sh86000001);
    push_query(FUNC_BY_VALUE, 32'sh7fffffff);
    push_query(FUNC_BY_VALUE, 32'sh94000010);
    push_query(FUNC_BY_VALUE, 32'sh80000000);
    drain();
    write_cfg(CFG_KEY_COUNT, 17'd127);
    write_cfg(CFG_FLAT_TOL, 17'd65536);
    push_query(FUNC_BY_VALUE, 32'sh94000005);
    push_query(FUNC_BY_VALUE, 32'sh98000000);
    push_query(FUNC_BY_TIME, 32'sh7ffffff0);
    push_key(3, 32'sh8c000000, 32'sh7fffffff);
    push_query(FUNC_BY_TIME, 32'sh8a000000);
    push_query(FUNC_BY_VALUE, 32'sh90000000);
    drain();
    write_cfg(CFG_KEY_COUNT, 17'd1);
    push_query(FUNC_BY_TIME, 32'sh00000000);
    push_query(FUNC_BY_VALUE, 32'sh80000000);
    drain();

    // Random phases over counts, tolerances and idling patterns.
    for (int ph = 0; ph < 8; ph++) begin
      mode = idle_mode_t'(ph % 4);
      m = (counts[ph] > NKEYS) ? NKEYS : counts[ph];
      write_cfg(CFG_KEY_COUNT, 17'(counts[ph]));
      r = ph % 4;
      write_cfg(CFG_FLAT_TOL, (r == 0) ? 17'd1 : (r == 1) ? 17'd0 :
                (r == 2) ? 17'd65536 : 17'($urandom_range(0, 65536)));
      if (ph == 1) hold_req = 1'b1;
      build_curve(m);
      for (int k = 0; k < 15; k++) begin
        r = $urandom_range(0, 19);
        f = (r < 9) ? FUNC_BY_TIME : FUNC_BY_VALUE;
        if (r < 16) push_query(f, near_key(f == FUNC_BY_VALUE, m));
        else if (r == 16) push_query(2'($urandom_range(1, 3)), $urandom);
        else if (r == 17) push_query(f, ($urandom_range(0, 1) != 0) ? 32'sh7fffffff
                                                                 : 32'sh80000000);
        else if (r == 18) push_key($urandom_range(0, NKEYS - 1), $urandom, $urandom);
        else push_query(f, $urandom);
      end
      drain();
    end

    if (err_count == 0) begin
      $display("tb_keyframe_curve_interpolator_top: done, clean");
    end else begin
      $display("tb_keyframe_curve_interpolator_top: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
